### hw/rtl/rme_pkg.sv
// Shared types and constants for the register machine execute block.
`timescale 1ns / 1ps

package rme_pkg;

	localparam int DATA_W            = 32;
	localparam int IDX_W             = 4;
	localparam int MADDR_W           = 10;
	localparam int NEXT_W            = 10;
	localparam int DATA_WORDS_DEF    = 1024;
	localparam int REG_COUNT_DEF     = 16;
	localparam int PROGRAM_WORDS_DEF = 1024;

	typedef enum logic [3:0] {
		FN_NOP     = 4'd0,
		FN_ADD     = 4'd1,
		FN_MUL     = 4'd2,
		FN_SUB     = 4'd3,
		FN_DIV     = 4'd4,
		FN_COPY    = 4'd5,
		FN_LOADIMM = 4'd6,
		FN_LOAD    = 4'd7,
		FN_STORE   = 4'd8,
		FN_EQ      = 4'd9,
		FN_LT      = 4'd10,
		FN_LE      = 4'd11,
		FN_GT      = 4'd12,
		FN_GE      = 4'd13,
		FN_JMP     = 4'd14,
		FN_JMPZ    = 4'd15
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_RD_D,
		ST_EXEC,
		ST_DIV,
		ST_WB
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [DATA_W-1:0]     dividend;
		logic [DATA_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DATA_W-1:0]     quotient;
	} div_rsp_t;

endpackage

### hw/rtl/rme_regfile.sv
// Register file: single read port with registered data, per-entry valid bits for reset.
`timescale 1ns / 1ps

module rme_regfile
	import rme_pkg::*;
#(
	parameter int REG_COUNT = REG_COUNT_DEF,
	localparam int RIDX_W   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RIDX_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata,
	input  logic              we,
	input  logic [RIDX_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata
);

	logic [DATA_W-1:0]    mem [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [DATA_W-1:0]    rd_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q     <= mem[raddr];
		rd_vld_q <= vld_q[raddr];
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

### hw/rtl/rme_dmem.sv
// Data memory: one write and one registered read port, cleared by a sweep after reset.
`timescale 1ns / 1ps

module rme_dmem
	import rme_pkg::*;
#(
	parameter int DATA_WORDS = DATA_WORDS_DEF,
	localparam int MA_W      = $clog2(DATA_WORDS)
) (
	input  logic              clk,
	input  logic              arst_n,
	output logic              clr_busy,
	input  logic [MA_W-1:0]   raddr,
	output logic [DATA_W-1:0] rdata,
	input  logic              we,
	input  logic [MA_W-1:0]   waddr,
	input  logic [DATA_W-1:0] wdata
);

	logic [DATA_W-1:0] mem [DATA_WORDS];
	logic [MA_W-1:0]   clr_cnt_q;
	logic              clr_busy_q;
	logic [DATA_W-1:0] rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == MA_W'(DATA_WORDS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign clr_busy = clr_busy_q;
	assign rdata    = rd_q;

endmodule

### hw/rtl/rme_div.sv
// Iterative signed divider: one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module rme_div
	import rme_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEPS = DATA_W;
	localparam int CNT_W = $clog2(STEPS);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_q;
	logic [DATA_W-1:0] rem_sh;
	logic [DATA_W:0]   diff;
	logic [DATA_W-1:0] mag_a;
	logic [DATA_W-1:0] mag_b;

	assign mag_a  = req.dividend[DATA_W-1] ? (~req.dividend + 1'b1) : req.dividend;
	assign mag_b  = req.divisor[DATA_W-1] ? (~req.divisor + 1'b1) : req.divisor;
	assign rem_sh = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
	assign diff   = {1'b0, rem_sh} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			dvs_q <= mag_b;
			neg_q <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

### hw/rtl/register_machine_execute.sv
// Top level: instruction sequencer and execute unit of the register machine.
`timescale 1ns / 1ps

// Executes one instruction per request transaction against a REG_COUNT-entry
// register file and a DATA_WORDS-word data memory, and returns one response
// transaction with the next program index and halt/divide-by-zero flags.
// After reset the data memory is swept to zero, one word per cycle, which
// holds off requests until the sweep ends. An instruction then passes from
// acceptance through three reads via the single register-file read port, an
// execute state and a write-back state that waits while the response is stalled.
// A divide with a nonzero divisor also passes through the bit-serial divider.
// Once halted, every request goes straight to write-back with a halted response.
module register_machine_execute
	import rme_pkg::*;
#(
	parameter int DATA_WORDS    = DATA_WORDS_DEF,
	parameter int REG_COUNT     = REG_COUNT_DEF,
	parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [IDX_W-1:0]         func,
	input  logic [IDX_W-1:0]         dest_index,
	input  logic [MADDR_W-1:0]       mem_address,
	input  logic [IDX_W-1:0]         src_a,
	input  logic [IDX_W-1:0]         src_b,
	input  logic signed [DATA_W-1:0] immediate,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic [NEXT_W-1:0]        next_index,
	output logic                     halted,
	output logic                     div_by_zero,
	output logic signed [DATA_W-1:0] result_value
);

	localparam int RIDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int MA_W   = $clog2(DATA_WORDS);
	localparam int PC_W   = $clog2(PROGRAM_WORDS);
	localparam int PCX_W  = PC_W + 1;

	function automatic logic [RIDX_W-1:0] reg_sel(input logic [IDX_W-1:0] v);
		logic [8:0] r;
		r = 9'(v);
		for (int k = 2; k >= 0; k--) begin
			if (r >= (9'(REG_COUNT) << k)) begin
				r = r - (9'(REG_COUNT) << k);
			end
		end
		return RIDX_W'(r);
	endfunction

	function automatic logic [MA_W-1:0] mem_sel(input logic [MADDR_W-1:0] v);
		logic [21:0] r;
		r = 22'(v);
		for (int k = 5; k >= 0; k--) begin
			if (r >= (22'(DATA_WORDS) << k)) begin
				r = r - (22'(DATA_WORDS) << k);
			end
		end
		return MA_W'(r);
	endfunction

	state_t state_q, state_d;

	func_t              func_q;
	logic [RIDX_W-1:0]  dst_q;
	logic [RIDX_W-1:0]  sa_q;
	logic [RIDX_W-1:0]  sb_q;
	logic [MA_W-1:0]    ma_q;
	logic [DATA_W-1:0]  imm_q;
	logic [DATA_W-1:0]  a_q;
	logic [DATA_W-1:0]  b_q;
	logic [DATA_W-1:0]  mem_q;
	logic [DATA_W-1:0]  res_q;
	logic               dz_q;
	logic               halt_q;
	logic               rwr_q;
	logic               mwr_q;
	logic [PC_W-1:0]    next_q;
	logic [PC_W-1:0]    pc_q;
	logic               stopped_q;

	logic               rsp_valid_q;
	logic [NEXT_W-1:0]  next_index_q;
	logic               halted_q;
	logic               div_by_zero_q;
	logic [DATA_W-1:0]  result_q;

	logic               accept;
	logic               out_free;
	logic               wb_go;
	logic [RIDX_W-1:0]  rf_raddr;
	logic [DATA_W-1:0]  rf_rdata;
	logic               dm_clr_busy;
	logic [DATA_W-1:0]  dm_rdata;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic [DATA_W-1:0]   ex_val;
	logic                ex_rwr;
	logic                ex_mwr;
	logic                ex_dz;
	logic                ex_div;
	logic                ex_jump;
	logic                ex_halt;
	logic [PC_W-1:0]     ex_next;
	logic [2*DATA_W-1:0] prod;
	logic [PCX_W-1:0]    inc;
	logic [DATA_W:0]     tgt;

	assign accept   = (state_q == ST_IDLE) && req_valid;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign wb_go    = (state_q == ST_WB) && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (!dm_clr_busy) state_d = ST_IDLE;
			ST_IDLE:  if (req_valid) state_d = stopped_q ? ST_WB : ST_RD_A;
			ST_RD_A:  state_d = ST_RD_B;
			ST_RD_B:  state_d = ST_RD_D;
			ST_RD_D:  state_d = ST_EXEC;
			ST_EXEC:  state_d = ex_div ? ST_DIV : ST_WB;
			ST_DIV:   if (div_rsp.done) state_d = ST_WB;
			ST_WB:    if (out_free) state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_stall     = 1'b1;
		rf_raddr      = sa_q;
		div_req.start = 1'b0;
		unique case (state_q)
			ST_CLEAR: req_stall = 1'b1;
			ST_IDLE:  req_stall = 1'b0;
			ST_RD_A:  rf_raddr = sa_q;
			ST_RD_B:  rf_raddr = sb_q;
			ST_RD_D:  rf_raddr = dst_q;
			ST_EXEC:  div_req.start = ex_div;
			ST_DIV:   req_stall = 1'b1;
			ST_WB:    req_stall = 1'b1;
		endcase
	end

	assign div_req.dividend = a_q;
	assign div_req.divisor  = b_q;

	assign prod = a_q * b_q;
	assign inc  = PCX_W'(pc_q) + 1'b1;
	assign tgt  = {rf_rdata[DATA_W-1], rf_rdata} + 1'b1;

	// execute
	always_comb begin
		ex_val  = '0;
		ex_rwr  = 1'b0;
		ex_mwr  = 1'b0;
		ex_dz   = 1'b0;
		ex_div  = 1'b0;
		ex_jump = 1'b0;
		unique case (func_q)
			FN_NOP:     ex_val = '0;
			FN_ADD:     begin ex_val = a_q + b_q; ex_rwr = 1'b1; end
			FN_MUL:     begin ex_val = prod[DATA_W-1:0]; ex_rwr = 1'b1; end
			FN_SUB:     begin ex_val = a_q - b_q; ex_rwr = 1'b1; end
			FN_DIV: begin
				ex_rwr = 1'b1;
				if (b_q == '0) begin
					ex_dz = 1'b1;
				end else begin
					ex_div = 1'b1;
				end
			end
			FN_COPY:    begin ex_val = a_q; ex_rwr = 1'b1; end
			FN_LOADIMM: begin ex_val = imm_q; ex_rwr = 1'b1; end
			FN_LOAD:    begin ex_val = mem_q; ex_rwr = 1'b1; end
			FN_STORE:   begin ex_val = a_q; ex_mwr = 1'b1; end
			FN_EQ:      begin ex_val = DATA_W'(a_q == b_q); ex_rwr = 1'b1; end
			FN_LT: begin
				ex_val = DATA_W'($signed(a_q) < $signed(b_q));
				ex_rwr = 1'b1;
			end
			FN_LE: begin
				ex_val = DATA_W'($signed(a_q) <= $signed(b_q));
				ex_rwr = 1'b1;
			end
			FN_GT: begin
				ex_val = DATA_W'($signed(a_q) > $signed(b_q));
				ex_rwr = 1'b1;
			end
			FN_GE: begin
				ex_val = DATA_W'($signed(a_q) >= $signed(b_q));
				ex_rwr = 1'b1;
			end
			FN_JMP:     ex_jump = 1'b1;
			FN_JMPZ:    ex_jump = (b_q == '0);
		endcase
		if (ex_jump) begin
			ex_halt = tgt[DATA_W] || (tgt >= (DATA_W + 1)'(PROGRAM_WORDS));
			ex_next = tgt[PC_W-1:0];
		end else begin
			ex_halt = (inc >= PCX_W'(PROGRAM_WORDS));
			ex_next = inc[PC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			pc_q        <= '0;
			stopped_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (wb_go) begin
				rsp_valid_q <= 1'b1;
				if (halt_q) begin
					stopped_q <= 1'b1;
					pc_q      <= '0;
				end else begin
					pc_q <= next_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(func);
			dst_q  <= reg_sel(dest_index);
			sa_q   <= reg_sel(src_a);
			sb_q   <= reg_sel(src_b);
			ma_q   <= mem_sel(mem_address);
			imm_q  <= immediate;
			res_q  <= '0;
			dz_q   <= 1'b0;
			halt_q <= 1'b1;
			rwr_q  <= 1'b0;
			mwr_q  <= 1'b0;
			next_q <= '0;
		end
		if (state_q == ST_RD_B) begin
			a_q   <= rf_rdata;
			mem_q <= dm_rdata;
		end
		if (state_q == ST_RD_D) begin
			b_q <= rf_rdata;
		end
		if (state_q == ST_EXEC) begin
			res_q  <= ex_val;
			dz_q   <= ex_dz;
			halt_q <= ex_halt;
			rwr_q  <= ex_rwr;
			mwr_q  <= ex_mwr;
			next_q <= ex_next;
		end
		if ((state_q == ST_DIV) && div_rsp.done) begin
			res_q <= div_rsp.quotient;
		end
		if (wb_go) begin
			next_index_q  <= halt_q ? '0 : NEXT_W'(next_q);
			halted_q      <= halt_q;
			div_by_zero_q <= dz_q;
			result_q      <= res_q;
		end
	end

	rme_regfile #(
		.REG_COUNT(REG_COUNT)
	) u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (rf_raddr),
		.rdata  (rf_rdata),
		.we     (wb_go && rwr_q),
		.waddr  (dst_q),
		.wdata  (res_q)
	);

	rme_dmem #(
		.DATA_WORDS(DATA_WORDS)
	) u_dmem (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr_busy (dm_clr_busy),
		.raddr    (ma_q),
		.rdata    (dm_rdata),
		.we       (wb_go && mwr_q),
		.waddr    (ma_q),
		.wdata    (res_q)
	);

	rme_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign rsp_valid    = rsp_valid_q;
	assign next_index   = next_index_q;
	assign halted       = halted_q;
	assign div_by_zero  = div_by_zero_q;
	assign result_value = result_q;

endmodule

### test/tb.sv
// Self-checking testbench for the register machine execute block.
`timescale 1ns / 1ps

module tb;
	import rme_pkg::*;

	localparam int LONG_HOLD   = 300;

	typedef struct packed {
		func_t               fn;
		logic [IDX_W-1:0]    dst;
		logic [MADDR_W-1:0]  addr;
		logic [IDX_W-1:0]    sa;
		logic [IDX_W-1:0]    sb;
		logic [DATA_W-1:0]   imm;
	} instr_t;

	typedef struct packed {
		logic [NEXT_W-1:0]   next_idx;
		logic                halt;
		logic                dz;
		logic [DATA_W-1:0]   value;
	} exec_result_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     req_valid    = 1'b0;
	logic                     req_stall;
	logic [IDX_W-1:0]         func         = '0;
	logic [IDX_W-1:0]         dest_index   = '0;
	logic [MADDR_W-1:0]       mem_address  = '0;
	logic [IDX_W-1:0]         src_a        = '0;
	logic [IDX_W-1:0]         src_b        = '0;
	logic signed [DATA_W-1:0] immediate    = '0;
	logic                     rsp_valid;
	logic                     rsp_stall    = 1'b0;
	logic [NEXT_W-1:0]        next_index;
	logic                     halted;
	logic                     div_by_zero;
	logic signed [DATA_W-1:0] result_value;

	logic [DATA_W-1:0] reg_model [REG_COUNT_DEF]  = '{default: '0};
	logic [DATA_W-1:0] mem_model [DATA_WORDS_DEF] = '{default: '0};
	int unsigned       prog_index      = 0;
	bit                machine_stopped = 1'b0;

	exec_result_t expected_q [$];
	int    errors         = 0;
	int    burst_left     = 0;
	int    hold_requests  = 0;
	int    hold_served    = 0;
	int    items_sent     = 0;
	int    results_seen   = 0;
	int    zero_divides   = 0;
	int    jumps_taken    = 0;
	int    after_halt     = 0;
	string halt_kind      = "none";

	register_machine_execute u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.func         (func),
		.dest_index   (dest_index),
		.mem_address  (mem_address),
		.src_a        (src_a),
		.src_b        (src_b),
		.immediate    (immediate),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.next_index   (next_index),
		.halted       (halted),
		.div_by_zero  (div_by_zero),
		.result_value (result_value)
	);

	always #6 clk = ~clk;

	function automatic longint jump_target(input logic [DATA_W-1:0] v);
		return longint'($signed(v)) + 1;
	endfunction

	function automatic bit target_in_program(input logic [DATA_W-1:0] v);
		return jump_target(v) >= 0 && jump_target(v) < PROGRAM_WORDS_DEF;
	endfunction

	function automatic exec_result_t execute_instr(input instr_t ins);
		exec_result_t      r;
		logic [DATA_W-1:0] a, b, ma, mb, q;
		logic              wr;
		longint            nxt;
		r = '0;
		if (machine_stopped) begin
			r.halt = 1'b1;
			return r;
		end
		a = reg_model[ins.sa];
		b = reg_model[ins.sb];
		nxt = longint'(prog_index) + 1;
		wr = 1'b1;
		case (ins.fn)
		FN_ADD:     r.value = a + b;
		FN_MUL:     r.value = a * b;
		FN_SUB:     r.value = a - b;
		FN_DIV: begin
			if (b == '0) begin
				r.dz = 1'b1;
				zero_divides++;
			end else begin
				ma = a[DATA_W-1] ? -a : a;
				mb = b[DATA_W-1] ? -b : b;
				q = ma / mb;
				r.value = (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
			end
		end
		FN_COPY:    r.value = a;
		FN_LOADIMM: r.value = ins.imm;
		FN_LOAD:    r.value = mem_model[ins.addr];
		FN_STORE: begin
			r.value = a;
			mem_model[ins.addr] = a;
			wr = 1'b0;
		end
		FN_EQ:      r.value = {31'd0, a == b};
		FN_LT:      r.value = {31'd0, $signed(a) < $signed(b)};
		FN_LE:      r.value = {31'd0, $signed(a) <= $signed(b)};
		FN_GT:      r.value = {31'd0, $signed(a) > $signed(b)};
		FN_GE:      r.value = {31'd0, $signed(a) >= $signed(b)};
		FN_JMP: begin
			nxt = jump_target(reg_model[ins.dst]);
			jumps_taken++;
			wr = 1'b0;
		end
		FN_JMPZ: begin
			if (b == '0) begin
				nxt = jump_target(reg_model[ins.dst]);
				jumps_taken++;
			end
			wr = 1'b0;
		end
		default:    wr = 1'b0;
		endcase
		if (wr)
			reg_model[ins.dst] = r.value;
		if (nxt < 0 || nxt >= PROGRAM_WORDS_DEF) begin
			r.halt = 1'b1;
			machine_stopped = 1'b1;
			prog_index = 0;
		end else begin
			prog_index = int'(nxt);
			r.next_idx = nxt[NEXT_W-1:0];
		end
		return r;
	endfunction

	function automatic instr_t mk(input func_t fn, input int dst, input int sa, input int sb,
			input int addr, input logic [DATA_W-1:0] imm);
		instr_t ins;
		ins.fn   = fn;
		ins.dst  = dst[IDX_W-1:0];
		ins.sa   = sa[IDX_W-1:0];
		ins.sb   = sb[IDX_W-1:0];
		ins.addr = addr[MADDR_W-1:0];
		ins.imm  = imm;
		return ins;
	endfunction

	// Keep the program index inside the program: jumps only use in-range targets,
	// and the index is pulled back before it can fall through the end.
	function automatic instr_t random_instr();
		instr_t           ins;
		logic [IDX_W-1:0] k;
		bit               found;
		ins.fn   = func_t'($urandom_range(0, 15));
		ins.dst  = IDX_W'($urandom);
		ins.sa   = IDX_W'($urandom);
		ins.sb   = IDX_W'($urandom);
		ins.addr = $urandom_range(0, 1) ? MADDR_W'($urandom) : MADDR_W'($urandom_range(0, 15));
		ins.imm  = $urandom;
		if ($urandom_range(0, 99) < 15)
			ins.fn = FN_LOADIMM;
		if (prog_index >= 1000)
			ins.fn = FN_JMP;
		if (ins.fn == FN_JMP || (ins.fn == FN_JMPZ && reg_model[ins.sb] == '0)) begin
			found = 1'b0;
			for (int i = 0; i < REG_COUNT_DEF; i++) begin
				k = ins.dst + IDX_W'(i);
				if (!found && target_in_program(reg_model[k])) begin
					ins.dst = k;
					found = 1'b1;
				end
			end
			if (!found) begin
				ins.fn = FN_LOADIMM;
				ins.imm = $urandom_range(0, PROGRAM_WORDS_DEF - 2);
			end
		end else if (ins.fn == FN_LOADIMM) begin
			case ($urandom_range(0, 5))
			0, 1: ins.imm = $urandom_range(0, PROGRAM_WORDS_DEF - 2);
			2: begin
				case ($urandom_range(0, 4))
				0: ins.imm = 32'h8000_0000;
				1: ins.imm = 32'h7FFF_FFFF;
				2: ins.imm = 32'hFFFF_FFFF;
				3: ins.imm = 32'h0000_0000;
				default: ins.imm = 32'h0000_0001;
				endcase
			end
			default: ;
			endcase
		end
		return ins;
	endfunction

	task automatic send_instr(input instr_t ins);
		int gap;
		bit was_stopped;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid   <= 1'b1;
		func        <= ins.fn;
		dest_index  <= ins.dst;
		mem_address <= ins.addr;
		src_a       <= ins.sa;
		src_b       <= ins.sb;
		immediate   <= ins.imm;
		do @(posedge clk); while (req_stall);
		was_stopped = machine_stopped;
		expected_q.push_back(execute_instr(ins));
		items_sent++;
		if (was_stopped && halt_kind != "none")
			after_halt++;
	endtask

	task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		errors++;
		$display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h", $time, what, want, got);
	endtask

	always @(posedge clk) begin : response_check
		exec_result_t got, want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got.next_idx = next_index;
			got.halt     = halted;
			got.dz       = div_by_zero;
			got.value    = result_value;
			@(negedge clk);
			results_seen++;
			if (expected_q.size() == 0) begin
				flag_mismatch("unexpected response, next_index", '0, DATA_W'(got.next_idx));
			end else begin
				want = expected_q.pop_front();
				if (got.next_idx !== want.next_idx)
					flag_mismatch("next_index", DATA_W'(want.next_idx), DATA_W'(got.next_idx));
				if (got.halt !== want.halt)
					flag_mismatch("halted", DATA_W'(want.halt), DATA_W'(got.halt));
				if (got.dz !== want.dz)
					flag_mismatch("div_by_zero", DATA_W'(want.dz), DATA_W'(got.dz));
				if (got.value !== want.value)
					flag_mismatch("result_value", want.value, got.value);
			end
		end
	end

	initial begin : stall_pattern
		int seg_left;
		int pct;
		seg_left = 0;
		pct = 0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served++;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(5, 60);
					case ($urandom_range(0, 3))
					0: pct = 0;
					1: pct = 25;
					2: pct = 50;
					default: pct = 85;
					endcase
				end
				seg_left--;
				rsp_stall <= ($urandom_range(1, 100) <= pct);
			end
		end
	end

	task automatic test_reset_state();
		send_instr(mk(FN_NOP, 0, 0, 0, 0, 0));
		send_instr(mk(FN_ADD, 0, 15, 15, 0, 0));
		send_instr(mk(FN_LOAD, 15, 0, 0, 1023, 0));
	endtask

	task automatic test_arith_extremes();
		send_instr(mk(FN_LOADIMM, 1, 0, 0, 0, 32'h7FFF_FFFF));
		send_instr(mk(FN_LOADIMM, 2, 0, 0, 0, 32'h8000_0000));
		send_instr(mk(FN_LOADIMM, 3, 0, 0, 0, 32'hFFFF_FFFF));
		send_instr(mk(FN_LOADIMM, 4, 0, 0, 0, 32'h0000_0000));
		send_instr(mk(FN_ADD, 5, 1, 1, 0, 0));
		send_instr(mk(FN_MUL, 6, 2, 3, 0, 0));
		send_instr(mk(FN_SUB, 7, 2, 1, 0, 0));
		// most negative over minus one wraps
		send_instr(mk(FN_DIV, 8, 2, 3, 0, 0));
		send_instr(mk(FN_DIV, 9, 1, 4, 0, 0));
		// mixed signs truncate toward zero
		send_instr(mk(FN_DIV, 10, 1, 5, 0, 0));
	endtask

	task automatic test_compares();
		send_instr(mk(FN_EQ, 11, 2, 2, 0, 0));
		send_instr(mk(FN_LT, 12, 2, 1, 0, 0));
		send_instr(mk(FN_LE, 13, 1, 2, 0, 0));
		send_instr(mk(FN_GT, 14, 1, 2, 0, 0));
		send_instr(mk(FN_GE, 11, 3, 3, 0, 0));
	endtask

	task automatic test_memory();
		send_instr(mk(FN_STORE, 0, 2, 0, 1023, 0));
		send_instr(mk(FN_LOAD, 12, 0, 0, 1023, 0));
		send_instr(mk(FN_STORE, 0, 1, 0, 0, 0));
		send_instr(mk(FN_COPY, 13, 2, 0, 0, 0));
	endtask

	task automatic test_jumps();
		send_instr(mk(FN_LOADIMM, 14, 0, 0, 0, 32'hFFFF_FFFF));
		send_instr(mk(FN_JMP, 14, 0, 0, 0, 0));
		send_instr(mk(FN_JMPZ, 14, 0, 4, 0, 0));
		send_instr(mk(FN_JMPZ, 14, 0, 1, 0, 0));
	endtask

	task automatic test_random_program(input int count);
		repeat (count) send_instr(random_instr());
	endtask

	task automatic test_input_backpressure();
		hold_requests++;
		repeat (40) send_instr(random_instr());
	endtask

	task automatic test_halt();
		case ($urandom_range(0, 2))
		0: begin
			halt_kind = "fall-through";
			send_instr(mk(FN_LOADIMM, 15, 0, 0, 0, PROGRAM_WORDS_DEF - 2));
			send_instr(mk(FN_JMP, 15, 0, 0, 0, 0));
			send_instr(mk(FN_NOP, 0, 0, 0, 0, 0));
		end
		1: begin
			halt_kind = "jump past the end";
			send_instr(mk(FN_LOADIMM, 15, 0, 0, 0, PROGRAM_WORDS_DEF - 1));
			send_instr(mk(FN_JMP, 15, 0, 0, 0, 0));
		end
		default: begin
			halt_kind = "negative jump target";
			send_instr(mk(FN_LOADIMM, 15, 0, 0, 0, 32'h8000_0000 + $urandom_range(0, 1000)));
			send_instr(mk(FN_JMP, 15, 0, 0, 0, 0));
		end
		endcase
		repeat (20) send_instr(random_instr());
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_arith_extremes();
		test_compares();
		test_memory();
		test_jumps();
		test_random_program(1700);
		test_input_backpressure();
		test_halt();
		req_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		$display("Ran %0d instructions with %0d responses checked: %0d divides by zero, %0d taken jumps.",
			items_sent, results_seen, zero_divides, jumps_taken);
		$display("Machine stopped on a %s, then answered %0d requests while halted.",
			halt_kind, after_halt);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
